### sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Shared widths, register indexes and reset values for the debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    // Default number of buttons handled side by side.
    localparam int NUM_BUTTONS_DEF = 4;

    // Millisecond time base and register widths.
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 10;
    localparam int REPEAT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS     = 2'd0,
        CFG_FIRST_REPEAT_MS = 2'd1,
        CFG_NEXT_REPEAT_MS  = 2'd2
    } cfg_index_t;

    // Register values after reset.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST     = 10'd20;
    localparam logic [REPEAT_W-1:0]   FIRST_REPEAT_RST = 16'd500;
    localparam logic [REPEAT_W-1:0]   NEXT_REPEAT_RST  = 16'd150;

endpackage : bda_pkg

`default_nettype wire

### sv/button_debounce_auto_repeat_top.sv
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat
// Samples raw active-low button levels on millisecond ticks, debounces them
// and emits press, release and auto-repeat flags for every tick.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Words
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | button_levels, one tick per word
//  out     | out_valid / out_stall | just_pressed, just_released, pressed_now
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
//  A tick word passes an input register and a result register; one word is
//  taken every cycle while the result side does not stall.
//  The per-button update is a 32-bit add and compare between the two stages.
//  Reset clears the millisecond counter, the sample and pressed state and
//  restores the register defaults. A stall on the result side holds the
//  result register and backs up into the input register before in_stall rises.
//
`default_nettype none

module button_debounce_auto_repeat_top
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [NUM_BUTTONS-1:0] button_levels,

    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [NUM_BUTTONS-1:0] just_pressed,
    output      logic [NUM_BUTTONS-1:0] just_released,
    output      logic [NUM_BUTTONS-1:0] pressed_now,

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [REPEAT_W-1:0]   first_repeat_ms_reg;
    logic [REPEAT_W-1:0]   next_repeat_ms_reg;

    // Pipeline control and payload.
    logic                   s1_valid_reg;
    logic [NUM_BUTTONS-1:0] s1_levels_reg;
    logic                   out_valid_reg;
    logic [NUM_BUTTONS-1:0] just_pressed_reg;
    logic [NUM_BUTTONS-1:0] just_released_reg;
    logic                   out_load;
    logic                   advance;

    // Debounce state.
    logic [TIME_W-1:0]      time_now_reg;
    logic [TIME_W-1:0]      last_sample_reg;
    logic [NUM_BUTTONS-1:0] prev_sample_reg;
    logic [NUM_BUTTONS-1:0] pressed_reg;
    logic [TIME_W-1:0]      deadline_reg [NUM_BUTTONS];

    logic [TIME_W-1:0]      last_sample_next;
    logic [NUM_BUTTONS-1:0] prev_sample_next;
    logic [NUM_BUTTONS-1:0] pressed_next;
    logic [TIME_W-1:0]      deadline_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] just_pressed_next;
    logic [NUM_BUTTONS-1:0] just_released_next;

    logic                   sample_tick;
    logic [TIME_W:0]        sample_due;
    logic [TIME_W-1:0]      now_plus_first;
    logic [TIME_W-1:0]      now_plus_next;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg     <= DEBOUNCE_RST;
            first_repeat_ms_reg <= FIRST_REPEAT_RST;
            next_repeat_ms_reg  <= NEXT_REPEAT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_data[DEBOUNCE_W-1:0];
                CFG_FIRST_REPEAT_MS: first_repeat_ms_reg <= cfg_data[REPEAT_W-1:0];
                CFG_NEXT_REPEAT_MS:  next_repeat_ms_reg  <= cfg_data[REPEAT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Handshake: the result register loads when empty or being taken.
    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_levels_reg <= button_levels;
        end
    end

    // Sampling test. After a counter wrap the last sample time is pulled
    // back to now, so only a zero debounce period samples on that tick.
    assign sample_due = {1'b0, last_sample_reg}
                      + {{(TIME_W + 1 - DEBOUNCE_W){1'b0}}, debounce_ms_reg};

    always_comb
    begin
        if (time_now_reg < last_sample_reg)
        begin
            sample_tick = (debounce_ms_reg == '0);
        end
        else
        begin
            sample_tick = (sample_due <= {1'b0, time_now_reg});
        end
    end

    assign now_plus_first = time_now_reg
                          + {{(TIME_W - REPEAT_W){1'b0}}, first_repeat_ms_reg};
    assign now_plus_next  = time_now_reg
                          + {{(TIME_W - REPEAT_W){1'b0}}, next_repeat_ms_reg};

    // Per-button debounce, press, release and auto-repeat update.
    always_comb
    begin
        last_sample_next   = (time_now_reg < last_sample_reg) ? time_now_reg
                                                              : last_sample_reg;
        prev_sample_next   = prev_sample_reg;
        pressed_next       = pressed_reg;
        just_pressed_next  = '0;
        just_released_next = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            deadline_next[i] = deadline_reg[i];
        end

        if (sample_tick)
        begin
            last_sample_next = time_now_reg;
            prev_sample_next = s1_levels_reg;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (s1_levels_reg[i] == prev_sample_reg[i])
                begin
                    if (!pressed_reg[i] && !s1_levels_reg[i])
                    begin
                        just_pressed_next[i] = 1'b1;
                        deadline_next[i]     = now_plus_first;
                    end
                    else if (pressed_reg[i] && s1_levels_reg[i])
                    begin
                        just_released_next[i] = 1'b1;
                        deadline_next[i]      = '0;
                    end
                    pressed_next[i] = !s1_levels_reg[i];
                    if (!s1_levels_reg[i] && (deadline_next[i] < time_now_reg))
                    begin
                        just_pressed_next[i] = 1'b1;
                        deadline_next[i]     = now_plus_next;
                    end
                end
            end
        end
    end

    // State and result update, once per tick word that moves forward.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg    <= '0;
            last_sample_reg <= '0;
            prev_sample_reg <= '0;
            pressed_reg     <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                deadline_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            time_now_reg    <= time_now_reg + TIME_W'(1);
            last_sample_reg <= last_sample_next;
            prev_sample_reg <= prev_sample_next;
            pressed_reg     <= pressed_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                deadline_reg[i] <= deadline_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            just_pressed_reg  <= just_pressed_next;
            just_released_reg <= just_released_next;
        end
    end

    // The pressed state register always matches the latest result word.
    assign out_valid     = out_valid_reg;
    assign just_pressed  = just_pressed_reg;
    assign just_released = just_released_reg;
    assign pressed_now   = pressed_reg;

    // A button is never reported pressed and released in one word.
    a_no_press_and_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((just_pressed & just_released) == '0))
        else $error("press and release flagged together");

    // A press flag implies the button reads pressed, a release flag that it does not.
    a_flags_match_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((just_pressed & ~pressed_now) == '0)
                    && ((just_released & pressed_now) == '0)))
        else $error("flags disagree with pressed state");

    // The millisecond counter moves by one for each tick word passed on.
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (time_now_reg == $past(time_now_reg) + TIME_W'(1)))
        else $error("millisecond counter did not step");

    // Back-pressure reaches the input only when the input register is full.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule : button_debounce_auto_repeat_top

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat testbench
// Sends millisecond tick words with raw button levels and predicts every
// press, release and auto-repeat flag. Each result word is checked against
// the oldest prediction. Phases change the timing registers while the block
// is idle and vary idling on both channels. One phase also holds the result
// side off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import bda_pkg::*;

    localparam int NB          = NUM_BUTTONS_DEF;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_SHOWN   = 40;

    typedef struct packed {
        logic [NB-1:0] jp;
        logic [NB-1:0] jr;
        logic [NB-1:0] pn;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [NB-1:0]         button_levels = '1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [NB-1:0]         just_pressed;
    logic [NB-1:0]         just_released;
    logic [NB-1:0]         pressed_now;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE_MS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Tick words waiting to be sent and results waiting to arrive.
    logic [NB-1:0] pending_ticks[$];
    tick_result_t  expected_flags[$];

    // Idling controls, set per phase.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;
    int   holds_started = 0;
    int   hold_left = 0;
    logic in_took = 1'b0;
    int   mismatch_count = 0;

    // Mirror of the timing registers.
    logic [DEBOUNCE_W-1:0] cur_debounce = DEBOUNCE_RST;
    logic [REPEAT_W-1:0]   cur_first = FIRST_REPEAT_RST;
    logic [REPEAT_W-1:0]   cur_next = NEXT_REPEAT_RST;

    // Mirror of the debounce state.
    logic [TIME_W-1:0] tick_now = '0;
    logic [TIME_W-1:0] last_sample_at = '0;
    logic [NB-1:0]     prev_level = '0;
    logic [NB-1:0]     held = '0;
    logic [TIME_W-1:0] deadline[NB];

    button_debounce_auto_repeat_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_levels (button_levels),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .just_pressed  (just_pressed),
        .just_released (just_released),
        .pressed_now   (pressed_now),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int b = 0; b < NB; b++)
            deadline[b] = '0;
    end

    // Works out the flags of one tick and advances the millisecond counter.
    function automatic tick_result_t debounce_tick(input logic [NB-1:0] levels);
        logic [TIME_W-1:0] now;
        tick_result_t      r;
        now = tick_now;
        r = '0;
        tick_now = now + 1;
        if (now < last_sample_at)
            last_sample_at = now;
        if (64'(last_sample_at) + 64'(cur_debounce) <= 64'(now))
        begin
            last_sample_at = now;
            for (int b = 0; b < NB; b++)
            begin
                if (levels[b] == prev_level[b])
                begin
                    if (!held[b] && !levels[b])
                    begin
                        r.jp[b] = 1'b1;
                        deadline[b] = now + TIME_W'(cur_first);
                    end
                    else if (held[b] && levels[b])
                    begin
                        r.jr[b] = 1'b1;
                        deadline[b] = '0;
                    end
                    held[b] = !levels[b];
                    // A button held past its deadline repeats.
                    if (held[b] && deadline[b] < now)
                    begin
                        r.jp[b] = 1'b1;
                        deadline[b] = now + TIME_W'(cur_next);
                    end
                end
                prev_level[b] = levels[b];
            end
        end
        r.pn = held;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Tick driver: takes the next word from the queue unless idling.
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                button_levels <= pending_ticks.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side stall: random, or a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_started)
        begin
            holds_started <= holds_started + 1;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on each accepted tick, check each accepted result.
    always @(posedge clk)
    begin
        tick_result_t want;
        tick_result_t got;
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_flags.push_back(debounce_tick(button_levels));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{jp: just_pressed, jr: just_released, pn: pressed_now};
            if (expected_flags.size() == 0)
            begin
                flag_mismatch($sformatf("result word %h with no tick waiting", got));
            end
            else
            begin
                want = expected_flags.pop_front();
                if (got.jp !== want.jp)
                    flag_mismatch($sformatf("just_pressed %b, want %b", got.jp, want.jp));
                if (got.jr !== want.jr)
                    flag_mismatch($sformatf("just_released %b, want %b", got.jr, want.jr));
                if (got.pn !== want.pn)
                    flag_mismatch($sformatf("pressed_now %b, want %b", got.pn, want.pn));
            end
        end
    end

    // Waits until every tick has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_valid || expected_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEBOUNCE_MS:     cur_debounce = value[DEBOUNCE_W-1:0];
            CFG_FIRST_REPEAT_MS: cur_first = value;
            CFG_NEXT_REPEAT_MS:  cur_next = value;
            default:             ;
        endcase
    endtask

    // Writes all three timing registers; junk rides in the unused data bits.
    task automatic set_timing(input int deb, input int first, input int next);
        wait_drained();
        write_reg(CFG_DEBOUNCE_MS, {6'($urandom), 10'(deb)});
        write_reg(CFG_FIRST_REPEAT_MS, 16'(first));
        write_reg(CFG_NEXT_REPEAT_MS, 16'(next));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly steady button patterns with rare glitches; some bursts of noise.
    task automatic queue_button_activity(input int n_items, input int hold_max);
        int            left;
        int            run;
        logic [NB-1:0] pattern;
        logic [NB-1:0] glitch;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(99) < 20)
            begin
                run = $urandom_range(1, 8);
                if (run > left)
                    run = left;
                for (int k = 0; k < run; k++)
                    pending_ticks.push_back(NB'($urandom));
            end
            else
            begin
                pattern = NB'($urandom);
                run = $urandom_range(1, hold_max);
                if (run > left)
                    run = left;
                for (int k = 0; k < run; k++)
                begin
                    glitch = ($urandom_range(99) < 5) ? NB'($urandom) : '0;
                    pending_ticks.push_back(pattern ^ glitch);
                end
            end
            left -= run;
        end
    endtask

    task automatic run_phase(input int deb, input int first, input int next,
                             input int send_pct, input int stall_pct,
                             input int n_items, input int hold_max);
        set_timing(deb, first, next);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        queue_button_activity(n_items, hold_max);
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset defaults: buttons held low at the first sample press at once.
        for (int k = 0; k < 21; k++)
            pending_ticks.push_back(4'b0110);

        // Short timing: press all, repeat, release all, bounce, settle.
        set_timing(1, 3, 2);
        for (int k = 0; k < 6; k++)
            pending_ticks.push_back(4'b0000);
        for (int k = 0; k < 3; k++)
            pending_ticks.push_back(4'b1111);
        pending_ticks.push_back(4'b0101);
        pending_ticks.push_back(4'b1010);
        pending_ticks.push_back(4'b0101);
        pending_ticks.push_back(4'b1010);
        pending_ticks.push_back(4'b1111);
        pending_ticks.push_back(4'b1111);
        pending_ticks.push_back(4'b0000);
        pending_ticks.push_back(4'b0000);

        run_phase(1, 3, 2, 0, 0, 250, 12);
        run_phase(2, 7, 1, 57, 0, 200, 30);
        run_phase(3, 1, 4, 0, 57, 200, 25);

        // Sampling on every tick; the result side holds off mid-phase.
        run_phase(0, 2, 3, 14, 14, 150, 10);
        while (pending_ticks.size() > 100)
            @(posedge clk);
        hold_requests++;

        // Repeat delays at their maximum: presses and releases only.
        run_phase(1, 65535, 65535, 0, 0, 100, 8);

        // Slowest sampling, default repeat delays written back.
        run_phase(1023, 500, 150, 14, 14, 1060, 900);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
